@@ rtl/mcm_pkg.sv @@
package mcm_pkg;

    localparam int ORG_BITS        = 6;
    localparam int NUM_AXES        = 3;
    localparam int NUM_CORNERS     = 8;
    localparam int NUM_EDGES       = 12;
    localparam int SCALE_BITS      = 16;
    localparam int HE_BITS         = 31;
    localparam int POS_BITS        = 32;
    localparam int IDX_BITS        = 32;
    localparam int PA_BITS         = ORG_BITS + 1;
    localparam int PAS_BITS        = PA_BITS + SCALE_BITS;
    localparam int QUOT_BITS       = SCALE_BITS;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 32;
    localparam int DEF_VALUE_BITS  = 16;
    localparam int OUT_DATA_BITS   = 3 * POS_BITS + 3 * IDX_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SURFACE_LEVEL = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTERP_MODE   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CELL_SCALE    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_EXT_X    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_EXT_Y    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_EXT_Z    = 3'd5;

    localparam logic [SCALE_BITS-1:0] RST_CELL_SCALE = 16'd256;
    localparam logic                  KIND_TRI       = 1'b0;
    localparam logic                  KIND_VERT      = 1'b1;
    localparam logic                  MODE_MIDPOINT  = 1'b0;

    typedef struct packed {
        logic       load_in;
        logic       setup;
        logic       mul;
        logic       div_step;
        logic       emit_tri;
        logic       emit_vert;
        logic       last;
        logic       bump_base;
        logic [2:0] tri_sel;
        logic [3:0] edge_sel;
    } t_cmd;

    typedef struct packed {
        logic       empty;
        logic [2:0] tri_cnt;
        logic       out_free;
    } t_sts;

    function automatic logic [2:0] edge_end_a(input logic [3:0] e);
        logic [2:0] r;
        case (e)
            4'd0, 4'd8:  r = 3'd0;
            4'd1, 4'd9:  r = 3'd1;
            4'd2, 4'd10: r = 3'd2;
            4'd3, 4'd11: r = 3'd3;
            4'd4:        r = 3'd4;
            4'd5:        r = 3'd5;
            4'd6:        r = 3'd6;
            4'd7:        r = 3'd7;
            default:     r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] edge_end_b(input logic [3:0] e);
        logic [2:0] r;
        case (e)
            4'd0:    r = 3'd1;
            4'd1:    r = 3'd2;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd0;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd6;
            4'd6:    r = 3'd7;
            4'd7:    r = 3'd4;
            4'd8:    r = 3'd4;
            4'd9:    r = 3'd5;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd7;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // corner offset as {z, y, x}
    function automatic logic [2:0] corner_off(input logic [2:0] c);
        logic [2:0] r;
        case (c)
            3'd0:    r = 3'b000;
            3'd1:    r = 3'b001;
            3'd2:    r = 3'b011;
            3'd3:    r = 3'b010;
            3'd4:    r = 3'b100;
            3'd5:    r = 3'b101;
            3'd6:    r = 3'b111;
            3'd7:    r = 3'b110;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

    // {triangle count, edge digits right aligned, first digit highest}
    function automatic logic [62:0] tri_row(input logic [7:0] c);
        logic [62:0] r;
        case (c)
            8'd1: r = {3'd1, 60'h083};
            8'd2: r = {3'd1, 60'h019};
            8'd3: r = {3'd2, 60'h183981};
            8'd4: r = {3'd1, 60'h12a};
            8'd5: r = {3'd2, 60'h08312a};
            8'd6: r = {3'd2, 60'h92a029};
            8'd7: r = {3'd3, 60'h2832a8a98};
            8'd8: r = {3'd1, 60'h3b2};
            8'd9: r = {3'd2, 60'h0b28b0};
            8'd10: r = {3'd2, 60'h19023b};
            8'd11: r = {3'd3, 60'h1b219b98b};
            8'd12: r = {3'd2, 60'h3a1ba3};
            8'd13: r = {3'd3, 60'h0a108a8ba};
            8'd14: r = {3'd3, 60'h39039bba9};
            8'd15: r = {3'd2, 60'h98aa8b};
            8'd16: r = {3'd1, 60'h478};
            8'd17: r = {3'd2, 60'h430734};
            8'd18: r = {3'd2, 60'h019847};
            8'd19: r = {3'd3, 60'h419471731};
            8'd20: r = {3'd2, 60'h12a847};
            8'd21: r = {3'd3, 60'h34730412a};
            8'd22: r = {3'd3, 60'h92a902847};
            8'd23: r = {3'd4, 60'h2a9297273794};
            8'd24: r = {3'd2, 60'h8473b2};
            8'd25: r = {3'd3, 60'hb47b24204};
            8'd26: r = {3'd3, 60'h90184723b};
            8'd27: r = {3'd4, 60'h47b94b9b2921};
            8'd28: r = {3'd3, 60'h3a13ba784};
            8'd29: r = {3'd4, 60'h1ba14b1047b4};
            8'd30: r = {3'd4, 60'h47890b9bab03};
            8'd31: r = {3'd3, 60'h47b4b99ba};
            8'd32: r = {3'd1, 60'h954};
            8'd33: r = {3'd2, 60'h954083};
            8'd34: r = {3'd2, 60'h054150};
            8'd35: r = {3'd3, 60'h854835315};
            8'd36: r = {3'd2, 60'h12a954};
            8'd37: r = {3'd3, 60'h30812a495};
            8'd38: r = {3'd3, 60'h52a542402};
            8'd39: r = {3'd4, 60'h2a5325354348};
            8'd40: r = {3'd2, 60'h95423b};
            8'd41: r = {3'd3, 60'h0b208b495};
            8'd42: r = {3'd3, 60'h05401523b};
            8'd43: r = {3'd4, 60'h21525828b485};
            8'd44: r = {3'd3, 60'ha3ba13954};
            8'd45: r = {3'd4, 60'h4950818a18ba};
            8'd46: r = {3'd4, 60'h54050b5bab03};
            8'd47: r = {3'd3, 60'h54858aa8b};
            8'd48: r = {3'd2, 60'h978579};
            8'd49: r = {3'd3, 60'h930953573};
            8'd50: r = {3'd3, 60'h078017157};
            8'd51: r = {3'd2, 60'h153357};
            8'd52: r = {3'd3, 60'h978957a12};
            8'd53: r = {3'd4, 60'ha12950530573};
            8'd54: r = {3'd4, 60'h802825857a52};
            8'd55: r = {3'd3, 60'h2a5253357};
            8'd56: r = {3'd3, 60'h7957893b2};
            8'd57: r = {3'd4, 60'h95797292027b};
            8'd58: r = {3'd4, 60'h23b018178157};
            8'd59: r = {3'd3, 60'hb21b17715};
            8'd60: r = {3'd4, 60'h958857a13a3b};
            8'd61: r = {3'd5, 60'h5705097b010aba0};
            8'd62: r = {3'd5, 60'hba0b03a50807570};
            8'd63: r = {3'd2, 60'hba57b5};
            8'd64: r = {3'd1, 60'ha65};
            8'd65: r = {3'd2, 60'h0835a6};
            8'd66: r = {3'd2, 60'h9015a6};
            8'd67: r = {3'd3, 60'h1831985a6};
            8'd68: r = {3'd2, 60'h165261};
            8'd69: r = {3'd3, 60'h165126308};
            8'd70: r = {3'd3, 60'h965906026};
            8'd71: r = {3'd4, 60'h598582526328};
            8'd72: r = {3'd2, 60'h23ba65};
            8'd73: r = {3'd3, 60'hb08b20a65};
            8'd74: r = {3'd3, 60'h01923b5a6};
            8'd75: r = {3'd4, 60'h5a61929b298b};
            8'd76: r = {3'd3, 60'h63b653513};
            8'd77: r = {3'd4, 60'h08b0b50515b6};
            8'd78: r = {3'd4, 60'h3b6036065059};
            8'd79: r = {3'd3, 60'h65969bb98};
            8'd80: r = {3'd2, 60'h5a6478};
            8'd81: r = {3'd3, 60'h43047365a};
            8'd82: r = {3'd3, 60'h1905a6847};
            8'd83: r = {3'd4, 60'ha65197173794};
            8'd84: r = {3'd3, 60'h612651478};
            8'd85: r = {3'd4, 60'h125526304347};
            8'd86: r = {3'd4, 60'h847905065026};
            8'd87: r = {3'd5, 60'h739794329596269};
            8'd88: r = {3'd3, 60'h3b2784a65};
            8'd89: r = {3'd4, 60'h5a647242027b};
            8'd90: r = {3'd4, 60'h01947823b5a6};
            8'd91: r = {3'd5, 60'h92192b94b7b45a6};
            8'd92: r = {3'd4, 60'h8473b53515b6};
            8'd93: r = {3'd5, 60'h51b5b610b7b404b};
            8'd94: r = {3'd5, 60'h059065036b63847};
            8'd95: r = {3'd4, 60'h65969b4797b9};
            8'd96: r = {3'd2, 60'ha4964a};
            8'd97: r = {3'd3, 60'h4a649a083};
            8'd98: r = {3'd3, 60'ha01a60640};
            8'd99: r = {3'd4, 60'h83181686461a};
            8'd100: r = {3'd3, 60'h149124264};
            8'd101: r = {3'd4, 60'h308129249264};
            8'd102: r = {3'd2, 60'h024426};
            8'd103: r = {3'd3, 60'h832824426};
            8'd104: r = {3'd3, 60'ha49a64b23};
            8'd105: r = {3'd4, 60'h08228b49a4a6};
            8'd106: r = {3'd4, 60'h3b201606461a};
            8'd107: r = {3'd5, 60'h64161a48121b8b1};
            8'd108: r = {3'd4, 60'h964936913b63};
            8'd109: r = {3'd5, 60'h8b1810b61914641};
            8'd110: r = {3'd3, 60'h3b6360064};
            8'd111: r = {3'd2, 60'h648b68};
            8'd112: r = {3'd3, 60'h7a678a89a};
            8'd113: r = {3'd4, 60'h0730a709a67a};
            8'd114: r = {3'd4, 60'ha671a7178180};
            8'd115: r = {3'd3, 60'ha67a71173};
            8'd116: r = {3'd4, 60'h126168189867};
            8'd117: r = {3'd5, 60'h269291679093739};
            8'd118: r = {3'd3, 60'h780706602};
            8'd119: r = {3'd2, 60'h732672};
            8'd120: r = {3'd4, 60'h23ba68a89867};
            8'd121: r = {3'd5, 60'h20727b09767a9a7};
            8'd122: r = {3'd5, 60'h1801781a767a23b};
            8'd123: r = {3'd4, 60'hb21b17a61671};
            8'd124: r = {3'd5, 60'h896867916b63136};
            8'd125: r = {3'd2, 60'h091b67};
            8'd126: r = {3'd4, 60'h7807063b0b60};
            8'd127: r = {3'd1, 60'h7b6};
            8'd128: r = {3'd1, 60'h76b};
            8'd129: r = {3'd2, 60'h308b76};
            8'd130: r = {3'd2, 60'h019b76};
            8'd131: r = {3'd3, 60'h819831b76};
            8'd132: r = {3'd2, 60'ha126b7};
            8'd133: r = {3'd3, 60'h12a3086b7};
            8'd134: r = {3'd3, 60'h2902a96b7};
            8'd135: r = {3'd4, 60'h6b72a3a83a98};
            8'd136: r = {3'd2, 60'h723627};
            8'd137: r = {3'd3, 60'h708760620};
            8'd138: r = {3'd3, 60'h276237019};
            8'd139: r = {3'd4, 60'h162186198876};
            8'd140: r = {3'd3, 60'ha76a17137};
            8'd141: r = {3'd4, 60'ha7617a187108};
            8'd142: r = {3'd4, 60'h03707a0a96a7};
            8'd143: r = {3'd3, 60'h76a7a88a9};
            8'd144: r = {3'd2, 60'h684b86};
            8'd145: r = {3'd3, 60'h36b306046};
            8'd146: r = {3'd3, 60'h86b846901};
            8'd147: r = {3'd4, 60'h946963931b36};
            8'd148: r = {3'd3, 60'h6846b82a1};
            8'd149: r = {3'd4, 60'h12a30b06b046};
            8'd150: r = {3'd4, 60'h4b846b0292a9};
            8'd151: r = {3'd5, 60'ha93a32943b36463};
            8'd152: r = {3'd3, 60'h823842462};
            8'd153: r = {3'd2, 60'h042462};
            8'd154: r = {3'd4, 60'h190234246438};
            8'd155: r = {3'd3, 60'h194142246};
            8'd156: r = {3'd4, 60'h8138618466a1};
            8'd157: r = {3'd3, 60'ha10a06604};
            8'd158: r = {3'd5, 60'h4634386a3039a93};
            8'd159: r = {3'd2, 60'ha946a4};
            8'd160: r = {3'd2, 60'h49576b};
            8'd161: r = {3'd3, 60'h083495b76};
            8'd162: r = {3'd3, 60'h50154076b};
            8'd163: r = {3'd4, 60'hb76834354315};
            8'd164: r = {3'd3, 60'h954a1276b};
            8'd165: r = {3'd4, 60'h6b712a083495};
            8'd166: r = {3'd4, 60'h76b54a42a402};
            8'd167: r = {3'd5, 60'h348354325a52b76};
            8'd168: r = {3'd3, 60'h723762549};
            8'd169: r = {3'd4, 60'h954086062687};
            8'd170: r = {3'd4, 60'h362376150540};
            8'd171: r = {3'd5, 60'h628687218485158};
            8'd172: r = {3'd4, 60'h954a16176137};
            8'd173: r = {3'd5, 60'h16a176107870954};
            8'd174: r = {3'd5, 60'h40a4a503a6a737a};
            8'd175: r = {3'd4, 60'h76a7a854a48a};
            8'd176: r = {3'd3, 60'h6956b9b89};
            8'd177: r = {3'd4, 60'h36b063056095};
            8'd178: r = {3'd4, 60'h0b805b01556b};
            8'd179: r = {3'd3, 60'h6b3635531};
            8'd180: r = {3'd4, 60'h12a95b9b8b56};
            8'd181: r = {3'd5, 60'h0b306b09656912a};
            8'd182: r = {3'd5, 60'hb85b56805a52025};
            8'd183: r = {3'd4, 60'h6b36352a3a53};
            8'd184: r = {3'd4, 60'h589528562382};
            8'd185: r = {3'd3, 60'h956960062};
            8'd186: r = {3'd5, 60'h158180568382628};
            8'd187: r = {3'd2, 60'h156216};
            8'd188: r = {3'd5, 60'h13616a386569896};
            8'd189: r = {3'd4, 60'ha10a06950560};
            8'd190: r = {3'd2, 60'h03856a};
            8'd191: r = {3'd1, 60'ha56};
            8'd192: r = {3'd2, 60'hb5a75b};
            8'd193: r = {3'd3, 60'hb5ab75830};
            8'd194: r = {3'd3, 60'h5b75ab190};
            8'd195: r = {3'd4, 60'ha75ab7981831};
            8'd196: r = {3'd3, 60'hb12b71751};
            8'd197: r = {3'd4, 60'h08312717572b};
            8'd198: r = {3'd4, 60'h9759279022b7};
            8'd199: r = {3'd5, 60'h75272b592328982};
            8'd200: r = {3'd3, 60'h25a235375};
            8'd201: r = {3'd4, 60'h820852875a25};
            8'd202: r = {3'd4, 60'h9015a35373a2};
            8'd203: r = {3'd5, 60'h982921872a25752};
            8'd204: r = {3'd2, 60'h135375};
            8'd205: r = {3'd3, 60'h087071175};
            8'd206: r = {3'd3, 60'h903935537};
            8'd207: r = {3'd2, 60'h987597};
            8'd208: r = {3'd3, 60'h5845a8ab8};
            8'd209: r = {3'd4, 60'h5045b05abb30};
            8'd210: r = {3'd4, 60'h01984a8aba45};
            8'd211: r = {3'd5, 60'hab4a45b34941314};
            8'd212: r = {3'd4, 60'h2512852b8458};
            8'd213: r = {3'd5, 60'h04b0b345b2b151b};
            8'd214: r = {3'd5, 60'h0250592b5458b85};
            8'd215: r = {3'd2, 60'h9452b3};
            8'd216: r = {3'd4, 60'h25a352345384};
            8'd217: r = {3'd3, 60'h5a2524420};
            8'd218: r = {3'd5, 60'h3a235a385458019};
            8'd219: r = {3'd4, 60'h5a2524192942};
            8'd220: r = {3'd3, 60'h845853351};
            8'd221: r = {3'd2, 60'h045105};
            8'd222: r = {3'd4, 60'h845853905035};
            8'd223: r = {3'd1, 60'h945};
            8'd224: r = {3'd3, 60'h4b749b9ab};
            8'd225: r = {3'd4, 60'h0834979b79ab};
            8'd226: r = {3'd4, 60'h1ab1b414074b};
            8'd227: r = {3'd5, 60'h3143481a474bab4};
            8'd228: r = {3'd4, 60'h4b79b492b912};
            8'd229: r = {3'd5, 60'h9749b791b2b1083};
            8'd230: r = {3'd3, 60'hb74b42240};
            8'd231: r = {3'd4, 60'hb74b42834324};
            8'd232: r = {3'd4, 60'h29a279237749};
            8'd233: r = {3'd5, 60'h9a7974a27870207};
            8'd234: r = {3'd5, 60'h37a3a274a1a040a};
            8'd235: r = {3'd2, 60'h1a2874};
            8'd236: r = {3'd3, 60'h491417713};
            8'd237: r = {3'd4, 60'h491417081871};
            8'd238: r = {3'd2, 60'h403743};
            8'd239: r = {3'd1, 60'h487};
            8'd240: r = {3'd2, 60'h9a8ab8};
            8'd241: r = {3'd3, 60'h30939bb9a};
            8'd242: r = {3'd3, 60'h01a0a88ab};
            8'd243: r = {3'd2, 60'h31ab3a};
            8'd244: r = {3'd3, 60'h12b1b99b8};
            8'd245: r = {3'd4, 60'h30939b1292b9};
            8'd246: r = {3'd2, 60'h02b80b};
            8'd247: r = {3'd1, 60'h32b};
            8'd248: r = {3'd3, 60'h23828aa89};
            8'd249: r = {3'd2, 60'h9a2092};
            8'd250: r = {3'd4, 60'h23828a0181a8};
            8'd251: r = {3'd1, 60'h1a2};
            8'd252: r = {3'd2, 60'h138918};
            8'd253: r = {3'd1, 60'h091};
            8'd254: r = {3'd1, 60'h038};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/mcm_ctrl.sv @@
module mcm_ctrl import mcm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLASS = 3'd1;
    localparam logic [2:0] ST_TRI   = 3'd2;
    localparam logic [2:0] ST_SETUP = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_VOUT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [3:0] r_edge, n_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_edge  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_edge  <= n_edge;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_edge     = r_edge;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.tri_sel  = r_cnt[2:0];
        o_cmd.edge_sel = r_edge;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_CLASS;
                end
            end
            ST_CLASS: begin
                n_cnt  = '0;
                n_edge = '0;
                if (i_sts.empty) begin
                    n_state = ST_IDLE;
                end else if (i_sts.tri_cnt == 3'd0) begin
                    n_state = ST_SETUP;
                end else begin
                    n_state = ST_TRI;
                end
            end
            ST_TRI: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_tri = 1'b1;
                    if (r_cnt[2:0] == i_sts.tri_cnt - 3'd1) begin
                        n_state = ST_SETUP;
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == 4'(QUOT_BITS - 1)) begin
                    n_state = ST_VOUT;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_VOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_vert = 1'b1;
                    if (r_edge == 4'(NUM_EDGES - 1)) begin
                        o_cmd.last      = 1'b1;
                        o_cmd.bump_base = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        n_edge  = r_edge + 4'd1;
                        n_state = ST_SETUP;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/mcm_datapath.sv @@
module mcm_datapath import mcm_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int IN_BITS    = ((NUM_AXES * ORG_BITS + NUM_CORNERS * VALUE_BITS + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [IN_BITS-1:0]       i_s_tdata,
    input  logic                     i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_m_tready,
    output logic                     o_m_tvalid,
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,
    output logic [0:0]               o_m_tuser,
    output logic                     o_m_tlast,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts
);

    localparam int VB     = VALUE_BITS;
    localparam int NUM_W  = VB + SCALE_BITS + 2;
    localparam int REM_W  = VB + 1;
    localparam int MOV_W  = PAS_BITS + 2;

    logic [VB-1:0]         r_level;
    logic                  r_mode;
    logic [SCALE_BITS-1:0] r_scale;
    logic [HE_BITS-1:0]    r_he [NUM_AXES];
    logic [IDX_BITS-1:0]   r_base;

    logic [ORG_BITS-1:0]   r_org [NUM_AXES];
    logic [VB-1:0]         r_val [NUM_CORNERS];

    logic [PAS_BITS-1:0]   r_pas [NUM_AXES];
    logic [VB-1:0]         r_n, r_d;
    logic                  r_eq_a, r_eq_b, r_up, r_active;
    logic [1:0]            r_axis;
    logic [REM_W-1:0]      r_rem;
    logic [QUOT_BITS-1:0]  r_sh;

    logic                  r_out_valid, r_kind, r_last;
    logic [POS_BITS-1:0]   r_pos [NUM_AXES];
    logic [IDX_BITS-1:0]   r_idx [NUM_AXES];

    // cube classification
    logic [NUM_CORNERS-1:0] cidx;
    logic [NUM_EDGES-1:0]   emask;
    logic [62:0]            row;
    logic [2:0]             tri_cnt;

    always_comb begin
        for (int k = 0; k < NUM_CORNERS; k++) begin
            cidx[k] = r_val[k] < r_level;
        end
        for (int e = 0; e < NUM_EDGES; e++) begin
            emask[e] = cidx[edge_end_a(4'(e))] ^ cidx[edge_end_b(4'(e))];
        end
        row     = tri_row(cidx);
        tri_cnt = row[62:60];
    end

    logic       out_free;
    assign out_free       = !r_out_valid || i_m_tready;
    assign o_sts.empty    = (emask == '0);
    assign o_sts.tri_cnt  = tri_cnt;
    assign o_sts.out_free = out_free;

    // triangle digits
    logic [2:0]  tri_back;
    logic [5:0]  tri_shift;
    logic [59:0] row_sh;
    logic [3:0]  dig [NUM_AXES];

    always_comb begin
        tri_back  = tri_cnt - 3'd1 - i_cmd.tri_sel;
        tri_shift = {tri_back, 3'b000} + {1'b0, tri_back, 2'b00};
        row_sh    = row[59:0] >> tri_shift;
        dig[0]    = row_sh[11:8];
        dig[1]    = row_sh[7:4];
        dig[2]    = row_sh[3:0];
    end

    // edge setup
    logic [2:0]       ca, cb, offa, offb;
    logic [VB-1:0]    va, vb;
    logic [1:0]       axis;
    logic [PA_BITS-1:0] pa [NUM_AXES];

    always_comb begin
        ca   = edge_end_a(i_cmd.edge_sel);
        cb   = edge_end_b(i_cmd.edge_sel);
        offa = corner_off(ca);
        offb = corner_off(cb);
        va   = r_val[ca];
        vb   = r_val[cb];
        axis = 2'd0;
        for (int k = 0; k < NUM_AXES; k++) begin
            pa[k] = {1'b0, r_org[k]} + PA_BITS'(offa[k]);
            if (offa[k] != offb[k]) begin
                axis = 2'(k);
            end
        end
    end

    // divider: f = (2*n*s + d) / (2*d), quotient fits the scale width
    logic [NUM_W-1:0] num;
    logic [REM_W:0]   dtrial;
    logic [REM_W:0]   dden;
    logic             dge;

    always_comb begin
        num    = {(VB + SCALE_BITS)'(r_n * r_scale), 1'b0} + NUM_W'(r_d);
        dden   = {1'b0, r_d, 1'b0};
        dtrial = {r_rem, r_sh[QUOT_BITS-1]};
        dge    = dtrial >= dden;
    end

    // vertex coordinate
    logic [MOV_W-1:0] pas_m, s_w, mov;
    logic [POS_BITS-1:0] vpos [NUM_AXES];

    always_comb begin
        pas_m = MOV_W'(r_pas[r_axis]);
        s_w   = MOV_W'(r_scale);
        if (r_mode == MODE_MIDPOINT) begin
            mov = ((r_up ? ({pas_m[MOV_W-2:0], 1'b0} + s_w)
                         : ({pas_m[MOV_W-2:0], 1'b0} - s_w)) + MOV_W'(1)) >> 1;
        end else if (r_eq_a) begin
            mov = pas_m;
        end else if (r_eq_b) begin
            mov = r_up ? pas_m + s_w : pas_m - s_w;
        end else begin
            mov = r_up ? pas_m + MOV_W'(r_sh) : pas_m - MOV_W'(r_sh);
        end
        for (int k = 0; k < NUM_AXES; k++) begin
            if (!r_active) begin
                vpos[k] = '0;
            end else if (2'(k) == r_axis) begin
                vpos[k] = POS_BITS'(mov) - POS_BITS'(r_he[k]);
            end else begin
                vpos[k] = POS_BITS'(r_pas[k]) - POS_BITS'(r_he[k]);
            end
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= {1'b1, {(VB-1){1'b0}}};
            r_mode      <= 1'b1;
            r_scale     <= RST_CELL_SCALE;
            r_he[0]     <= '0;
            r_he[1]     <= '0;
            r_he[2]     <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SURFACE_LEVEL: r_level <= i_cfg_data[VB-1:0];
                    CFG_INTERP_MODE:   r_mode  <= i_cfg_data[0];
                    CFG_CELL_SCALE:    r_scale <= i_cfg_data[SCALE_BITS-1:0];
                    CFG_HALF_EXT_X:    r_he[0] <= i_cfg_data[HE_BITS-1:0];
                    CFG_HALF_EXT_Y:    r_he[1] <= i_cfg_data[HE_BITS-1:0];
                    CFG_HALF_EXT_Z:    r_he[2] <= i_cfg_data[HE_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.bump_base) begin
                r_base <= r_base + IDX_BITS'(NUM_EDGES);
            end
            if (i_cmd.emit_tri || i_cmd.emit_vert) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_org[k] <= i_s_tdata[k*ORG_BITS +: ORG_BITS];
            end
            for (int k = 0; k < NUM_CORNERS; k++) begin
                r_val[k] <= i_s_tdata[NUM_AXES*ORG_BITS + k*VB +: VB];
            end
        end
        if (i_cmd.setup) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_pas[k] <= PAS_BITS'(pa[k] * r_scale);
            end
            r_n      <= (r_level > va) ? r_level - va : va - r_level;
            r_d      <= (vb > va) ? vb - va : va - vb;
            r_eq_a   <= (r_level == va) || (va == vb);
            r_eq_b   <= (r_level == vb);
            r_up     <= offb[axis] && !offa[axis];
            r_active <= emask[i_cmd.edge_sel];
            r_axis   <= axis;
        end
        if (i_cmd.mul) begin
            r_rem <= num[NUM_W-2:QUOT_BITS];
            r_sh  <= num[QUOT_BITS-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= dge ? REM_W'(dtrial - dden) : REM_W'(dtrial);
            r_sh  <= {r_sh[QUOT_BITS-2:0], dge};
        end
        if (i_cmd.emit_tri) begin
            r_kind <= KIND_TRI;
            r_last <= 1'b0;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_pos[k] <= '0;
                r_idx[k] <= r_base + IDX_BITS'(dig[k]);
            end
        end
        if (i_cmd.emit_vert) begin
            r_kind <= KIND_VERT;
            r_last <= i_cmd.last;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_pos[k] <= vpos[k];
                r_idx[k] <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {r_idx[2], r_idx[1], r_idx[0], r_pos[2], r_pos[1], r_pos[0]};

endmodule

@@ rtl/marching_cubes_cell_mesher_unit.sv @@
// An empty cube is dropped in the classify state that follows the taken request.
// Otherwise triangles leave one per cycle while the output is free, then each of the twelve
// vertices passes setup, multiply, the 16-step shared edge divider and output.
// A new cube is taken only after the last vertex of the previous cube is emitted.
// Reset (i_rst_n low, synchronous): registers to defaults, vertex base zero, idle.
module marching_cubes_cell_mesher_unit import mcm_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int IN_BITS    = ((NUM_AXES * ORG_BITS + NUM_CORNERS * VALUE_BITS + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // origin_x, origin_y, origin_z, corner_value_0 .. corner_value_7, zero fill
    input  logic [IN_BITS-1:0]       i_s_tdata,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // pos_x, pos_y, pos_z, index_a, index_b, index_c
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,
    // result_kind
    output logic [0:0]               o_m_tuser,
    output logic                     o_m_tlast,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    mcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mcm_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .IN_BITS    (IN_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
